/* sv/callback_timer_table_unit_defines.svh */
// Assertion macros used by the checker module.
`ifndef CALLBACK_TIMER_TABLE_UNIT_DEFINES_SVH
`define CALLBACK_TIMER_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ctt_pkg.sv */
package ctt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_WIDTH = 32;

    localparam int FIELD_TIME_W = 32;
    localparam int TAG_W        = 16;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    typedef logic [TIME_WIDTH-1:0] time_t;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic EV_ACK  = 1'b0;
    localparam logic EV_FIRE = 1'b1;

    localparam logic STAT_ACCEPTED = 1'b0;
    localparam logic STAT_FULL     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK_START,
        ST_TICK_PROC,
        ST_TICK_END
    } ctt_state_t;

    typedef struct packed {
        time_t            period;
        time_t            elapsed;
        logic             rep;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             event_res;
        logic [TAG_W-1:0] fired_tag;
        logic             status;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic latch;
        logic add_commit;
        logic tick_init;
        logic proc_step;
        logic tick_finish;
    } ctt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic fire;
        logic pend_valid;
        logic rd_last;
        logic count_zero;
    } ctt_stat_t;

    // Mask or zero-extend a port time field to the internal time width.
    function automatic time_t to_time(logic [FIELD_TIME_W-1:0] x);
        logic [63:0] w;
        w = {{(64-FIELD_TIME_W){1'b0}}, x};
        return w[TIME_WIDTH-1:0];
    endfunction

endpackage

/* sv/ctt_ifs.sv */
interface ctt_req_if
    import ctt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [FIELD_TIME_W-1:0] delta;
    logic [FIELD_TIME_W-1:0] period;
    logic                    repeat_req;
    logic [TAG_W-1:0]        tag;

    modport source (output valid, kind, delta, period, repeat_req, tag, input ready);
    modport sink   (input valid, kind, delta, period, repeat_req, tag, output ready);
endinterface

interface ctt_rsp_if
    import ctt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             event_res;
    logic [TAG_W-1:0] fired_tag;
    logic             status;
    logic             last;

    modport source (output valid, event_res, fired_tag, status, last, input ready);
    modport sink   (input valid, event_res, fired_tag, status, last, output ready);
endinterface

/* sv/ctt_ctrl.sv */
module ctt_ctrl
    import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_kind,
    output logic      req_ready,
    input  ctt_stat_t stat,
    output ctt_cmd_t  cmd
);

    ctt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (req_kind == KIND_ADD) ? ST_ADD : ST_TICK_START;
                end
            end
            ST_ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.add_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_TICK_START:
            begin
                cmd.tick_init = 1'b1;
                state_next    = stat.count_zero ? ST_IDLE : ST_TICK_PROC;
            end
            ST_TICK_PROC:
            begin
                // hold while a second fire needs the busy output register
                if (!(stat.fire && stat.pend_valid && !stat.out_free))
                begin
                    cmd.proc_step = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = ST_TICK_END;
                    end
                end
            end
            ST_TICK_END:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.tick_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/ctt_dpath.sv */
module ctt_dpath
    import ctt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctt_cmd_t                cmd,
    output ctt_stat_t               stat,
    input  logic [FIELD_TIME_W-1:0] in_delta,
    input  logic [FIELD_TIME_W-1:0] in_period,
    input  logic                    in_repeat,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rsp_t                    out_data
);

    entry_t mem [NUM_TIMERS];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] rd_inc;
    logic             pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0] pend_tag_reg, pend_tag_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_data_reg, out_data_next;

    time_t            delta_reg;
    time_t            period_reg;
    logic             rep_reg;
    logic [TAG_W-1:0] tag_reg;

    entry_t           rdata_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic [TIME_WIDTH:0] sum;
    time_t               acc;
    logic                fire;
    logic                keep;
    logic                full;
    logic                out_free;

    assign full     = (count_reg == CNT_W'(NUM_TIMERS));
    assign out_free = !out_valid_reg || out_ready;
    assign rd_inc   = rd_reg + CNT_W'(1);

    // saturating accumulate of the entry under visit
    assign sum  = {1'b0, rdata_reg.elapsed} + {1'b0, delta_reg};
    assign acc  = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    assign fire = (acc >= rdata_reg.period);
    assign keep = !fire || rdata_reg.rep;

    assign stat.out_free   = out_free;
    assign stat.fire       = fire;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.rd_last    = (rd_inc == count_reg);
    assign stat.count_zero = (count_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = '{period: period_reg, elapsed: '0, rep: rep_reg, tag: tag_reg};

        if (cmd.add_commit)
        begin
            wr_en          = !full;
            count_next     = full ? count_reg : count_reg + CNT_W'(1);
            out_valid_next = 1'b1;
            out_data_next  = '{event_res: EV_ACK, fired_tag: tag_reg,
                               status: full ? STAT_FULL : STAT_ACCEPTED, last: 1'b1};
        end

        if (cmd.tick_init)
        begin
            rd_next         = '0;
            wr_next         = '0;
            pend_valid_next = 1'b0;
            rd_en           = 1'b1;
        end

        if (cmd.proc_step)
        begin
            wr_en   = keep;
            wr_addr = wr_reg[IDX_W-1:0];
            wr_data = '{period: rdata_reg.period, elapsed: fire ? '0 : acc,
                        rep: rdata_reg.rep, tag: rdata_reg.tag};
            if (keep)
            begin
                wr_next = wr_reg + CNT_W'(1);
            end
            // a new fire releases the previous one, which is then not last
            if (fire)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{event_res: EV_FIRE, fired_tag: pend_tag_reg,
                                       status: STAT_ACCEPTED, last: 1'b0};
                end
                pend_valid_next = 1'b1;
                pend_tag_next   = rdata_reg.tag;
            end
            rd_next = rd_inc;
            rd_en   = 1'b1;
            rd_addr = rd_inc[IDX_W-1:0];
        end

        if (cmd.tick_finish)
        begin
            count_next = wr_reg;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = '{event_res: EV_FIRE, fired_tag: pend_tag_reg,
                                    status: STAT_ACCEPTED, last: 1'b1};
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tag_reg <= pend_tag_next;
        out_data_reg <= out_data_next;
        if (cmd.latch)
        begin
            delta_reg  <= to_time(in_delta);
            period_reg <= to_time(in_period);
            rep_reg    <= in_repeat;
            tag_reg    <= in_tag;
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

/* sv/callback_timer_table_unit.sv */
// Callback timer table: an ordered list of up to NUM_TIMERS timers (period, elapsed
// time, repeat flag, 16-bit tag), times in unsigned Q16.16 held in TIME_WIDTH bits.
// An add request appends a timer and answers with one acknowledgement (status 1 when
// the table is full and the request is dropped). A tick request adds its delta to
// every timer in table order, saturating; each timer whose elapsed time reaches its
// period returns one fire result with its tag, has its elapsed time cleared, and, if
// one-shot, leaves the table, which closes up in insertion order. The last result of
// a request carries last = 1; a tick that fires nothing returns no result. Requests
// are taken one at a time: an add is accepted and then committed, and a tick passes
// through accept, a first entry read, one step per stored timer and a close-out. The
// entry memory, with one registered read and one write per cycle, is visited one
// entry per cycle while the result register can take a fire; a result register that
// is not drained holds the add commit, the walk and the close-out. A finished result
// waits in the output register while the next request is accepted.
module callback_timer_table_unit
    import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ctt_req_if.sink   req,
    ctt_rsp_if.source rsp
);

    ctt_cmd_t  cmd;
    ctt_stat_t stat;
    rsp_t      out_data;
    logic      out_valid;

    // sequence one request: add, or a walk over the table
    ctt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // entry memory, accumulate and compare, held fire and result register
    ctt_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_delta  (req.delta),
        .in_period (req.period),
        .in_repeat (req.repeat_req),
        .in_tag    (req.tag),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    // drive the result channel from the output register
    assign rsp.valid     = out_valid;
    assign rsp.event_res = out_data.event_res;
    assign rsp.fired_tag = out_data.fired_tag;
    assign rsp.status    = out_data.status;
    assign rsp.last      = out_data.last;

endmodule

/* sv/ctt_checker.sv */
`include "callback_timer_table_unit_defines.svh"

module ctt_checker
    import ctt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_event_res,
    input logic [TAG_W-1:0] rsp_fired_tag,
    input logic             rsp_status,
    input logic             rsp_last
);

    `CTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
    `CTT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_fired_tag) && $stable(rsp_last), "result changed while stalled")
    `CTT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
    `CTT_ASSERT_NOW(a_ack_last, rsp_valid && rsp_event_res == EV_ACK, rsp_last, "add acknowledgement not last")
    `CTT_ASSERT_NOW(a_fire_status, rsp_valid && rsp_event_res == EV_FIRE, rsp_status == STAT_ACCEPTED, "fire result with nonzero status")

endmodule

bind callback_timer_table_unit ctt_checker u_ctt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_event_res (rsp.event_res),
    .rsp_fired_tag (rsp.fired_tag),
    .rsp_status    (rsp.status),
    .rsp_last      (rsp.last)
);

/* tb/sv/tb_callback_timer_table_unit.sv */
module tb_callback_timer_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ctt_pkg::*;

    // Stop a hung run. A tick walks the whole table once, and each of its results
    // can wait out a receiver stall. Add the long hold-off and bursty gaps,
    // then take the total several times over.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER_REQ = 80;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_REQS    = 220;

    // One request as it sits in the stimulus queue. Set drain_first to hold
    // the request back until every expected result has come out.
    typedef struct {
        logic                    kind;
        logic [FIELD_TIME_W-1:0] delta;
        logic [FIELD_TIME_W-1:0] period;
        logic                    repeat_req;
        logic [TAG_W-1:0]        tag;
        bit                      drain_first;
    } timer_req_t;

    logic clk = 1'b0;
    logic rst_n;

    ctt_req_if req_ch ();
    ctt_rsp_if rsp_ch ();

    callback_timer_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Stimulus waiting for the driver, and results the table owes us.
    timer_req_t pending_reqs[$];
    rsp_t       expected_events[$];

    // Shadow of the timer table, kept in step with accepted requests.
    time_t            tbl_period  [NUM_TIMERS];
    time_t            tbl_elapsed [NUM_TIMERS];
    logic             tbl_repeat  [NUM_TIMERS];
    logic [TAG_W-1:0] tbl_tag     [NUM_TIMERS];
    int               tbl_count = 0;

    int         error_count  = 0;
    int         accepted_cnt = 0;
    int         cycle_cnt    = 0;
    int         burst_left;
    int         gap_left;
    int         hold_left;
    bit         long_hold_done;
    logic [7:0] stall_phase;
    timer_req_t next_req;

    initial begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted request to the shadow table and queue the results it
    // must produce. An add always answers once. A tick answers once per fired
    // timer, in table order, and closes up the table behind removed one-shots.
    function automatic void predict_timer_request(timer_req_t it);
        time_t              d;
        time_t              acc;
        logic [TIME_WIDTH:0] sum;
        rsp_t               ev;
        rsp_t               fires[$];
        int                 rd;
        int                 wr;
        bit                 keep;
        d = TIME_WIDTH'(it.delta);
        if (it.kind == KIND_ADD) begin
            ev.event_res = EV_ACK;
            ev.fired_tag = it.tag;
            ev.last      = 1'b1;
            if (tbl_count < NUM_TIMERS) begin
                tbl_period[tbl_count]  = TIME_WIDTH'(it.period);
                tbl_elapsed[tbl_count] = '0;
                tbl_repeat[tbl_count]  = it.repeat_req;
                tbl_tag[tbl_count]     = it.tag;
                tbl_count++;
                ev.status = STAT_ACCEPTED;
            end
            else begin
                ev.status = STAT_FULL;
            end
            expected_events.push_back(ev);
        end
        else begin
            wr = 0;
            for (rd = 0; rd < tbl_count; rd++) begin
                keep = 1'b1;
                // Saturate the accumulator instead of wrapping.
                sum  = {1'b0, tbl_elapsed[rd]} + {1'b0, d};
                acc  = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
                if (acc >= tbl_period[rd]) begin
                    ev.event_res = EV_FIRE;
                    ev.fired_tag = tbl_tag[rd];
                    ev.status    = STAT_ACCEPTED;
                    ev.last      = 1'b0;
                    fires.push_back(ev);
                    acc = '0;
                    if (!tbl_repeat[rd])
                        keep = 1'b0;
                end
                if (keep) begin
                    tbl_period[wr]  = tbl_period[rd];
                    tbl_elapsed[wr] = acc;
                    tbl_repeat[wr]  = tbl_repeat[rd];
                    tbl_tag[wr]     = tbl_tag[rd];
                    wr++;
                end
            end
            tbl_count = wr;
            foreach (fires[k]) begin
                ev      = fires[k];
                ev.last = (k == fires.size() - 1);
                expected_events.push_back(ev);
            end
        end
    endfunction

    // Pick a time value: mostly small so timers fire after a few ticks, with
    // zero, all-ones and full-range values mixed in.
    function automatic logic [FIELD_TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return FIELD_TIME_W'($urandom);
            default: return FIELD_TIME_W'($urandom_range(0, 32'h0003_0000));
        endcase
    endfunction

    // Queue an add. The delta field is unused for adds, so fill it at random.
    task automatic queue_add(input logic [FIELD_TIME_W-1:0] period, input logic rep,
                             input logic [TAG_W-1:0] tag, input bit drain);
        timer_req_t it;
        it.kind        = KIND_ADD;
        it.delta       = FIELD_TIME_W'($urandom);
        it.period      = period;
        it.repeat_req  = rep;
        it.tag         = tag;
        it.drain_first = drain;
        pending_reqs.push_back(it);
    endtask

    // Queue a tick. Period, repeat flag and tag are ignored; randomize them.
    task automatic queue_tick(input logic [FIELD_TIME_W-1:0] delta, input bit drain);
        timer_req_t it;
        it.kind        = KIND_TICK;
        it.delta       = delta;
        it.period      = FIELD_TIME_W'($urandom);
        it.repeat_req  = 1'($urandom);
        it.tag         = TAG_W'($urandom);
        it.drain_first = drain;
        pending_reqs.push_back(it);
    endtask

    // Main sequence: build the stimulus, release reset, wait for the table to
    // drain, then report.
    initial begin
        int  i;
        bit  drain;
        rst_n = 1'b0;

        // Directed part.
        // Tick an empty table: no result expected.
        queue_tick('0, 1'b0);
        // Zero-period periodic timer fires on every tick, even with zero delta.
        queue_add('0, 1'b1, 16'hFFFF, 1'b0);
        queue_tick('0, 1'b0);
        // Largest period, periodic, plus a one-shot of one second.
        queue_add('1, 1'b1, 16'h0000, 1'b0);
        queue_add(32'h0001_0000, 1'b0, 16'h1234, 1'b0);
        // Full-scale delta saturates every accumulator: all three fire and the
        // one-shot leaves the table.
        queue_tick('1, 1'b0);
        // Two half-scale ticks: the second overflows and saturates.
        queue_tick(32'h8000_0000, 1'b0);
        queue_tick(32'h8000_0000, 1'b0);
        // Fill the table with one-shots, then overflow it twice.
        for (i = 0; i < NUM_TIMERS - 2; i++)
            queue_add(FIELD_TIME_W'($urandom), 1'b0, TAG_W'($urandom), 1'b0);
        queue_add(FIELD_TIME_W'($urandom), 1'b1, 16'hA5A5, 1'b0);
        queue_add(FIELD_TIME_W'($urandom), 1'b0, 16'h5A5A, 1'b0);
        // Fire the whole full table in one tick.
        queue_tick('1, 1'b0);

        // Random part. Keep periodic timers rare so the table keeps turning
        // over; every so often hold a request until all results are out.
        for (i = 0; i < RANDOM_REQS; i++) begin
            drain = (i % 60 == 30);
            if ($urandom_range(0, 99) < 42)
                queue_add(pick_time(), ($urandom_range(0, 99) < 12), TAG_W'($urandom), drain);
            else
                queue_tick(pick_time(), drain);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last transfer, then for every owed result.
        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        // Let any late result show up as unexpected.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_events.size() == 0)
            $display("tb_callback_timer_table_unit: done, clean");
        else
            $display("tb_callback_timer_table_unit: done, errors");
        $finish;
    end

    // Request driver. Hold a stalled transfer, otherwise offer the next queued
    // request in bursts of random length with random gaps. A request marked
    // drain_first waits until the bus has been idle a cycle and nothing is owed.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.kind       <= KIND_ADD;
            req_ch.delta      <= '0;
            req_ch.period     <= '0;
            req_ch.repeat_req <= 1'b0;
            req_ch.tag        <= '0;
            burst_left        <= 1;
            gap_left          <= 0;
        end
        else if (req_ch.valid && !req_ch.ready) begin
            // Hold the current request until it is taken.
        end
        else if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end
        else if (pending_reqs.size() != 0 &&
                 (!pending_reqs[0].drain_first ||
                  (!req_ch.valid && expected_events.size() == 0))) begin
            next_req = pending_reqs.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.kind       <= next_req.kind;
            req_ch.delta      <= next_req.delta;
            req_ch.period     <= next_req.period;
            req_ch.repeat_req <= next_req.repeat_req;
            req_ch.tag        <= next_req.tag;
            if (burst_left <= 1) begin
                // Start a new burst; half the time without any gap.
                burst_left <= $urandom_range(1, 24);
                gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            end
            else begin
                burst_left <= burst_left - 1;
            end
        end
        else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Result receiver. Cycle through stall patterns: always ready, coin flip,
    // mostly stalled, and a fixed periodic stall. Once, after enough requests
    // have gone in, hold off for a long stretch so the unit backs up.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready   <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
            stall_phase    <= '0;
        end
        else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!long_hold_done && accepted_cnt >= HOLD_AFTER_REQ) begin
            rsp_ch.ready   <= 1'b0;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else begin
            stall_phase <= stall_phase + 1'b1;
            case (stall_phase[7:6])
                2'd0: rsp_ch.ready <= 1'b1;
                2'd1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                2'd2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= (stall_phase[2:0] != 3'd5);
            endcase
        end
    end

    // Monitor and scoreboard in one process: predict on every request
    // transfer, then check every result transfer against the oldest owed one.
    always @(posedge clk) begin
        rsp_t exp_ev;
        timer_req_t seen;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                seen.kind        = req_ch.kind;
                seen.delta       = req_ch.delta;
                seen.period      = req_ch.period;
                seen.repeat_req  = req_ch.repeat_req;
                seen.tag         = req_ch.tag;
                seen.drain_first = 1'b0;
                predict_timer_request(seen);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_events.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, got ev=%0b tag=%h st=%0b last=%0b",
                             $time, rsp_ch.event_res, rsp_ch.fired_tag,
                             rsp_ch.status, rsp_ch.last);
                end
                else begin
                    exp_ev = expected_events.pop_front();
                    if (rsp_ch.event_res !== exp_ev.event_res ||
                        rsp_ch.fired_tag !== exp_ev.fired_tag ||
                        rsp_ch.status    !== exp_ev.status    ||
                        rsp_ch.last      !== exp_ev.last) begin
                        error_count++;
                        $display("%0t: result mismatch: expected ev=%0b tag=%h st=%0b last=%0b, got ev=%0b tag=%h st=%0b last=%0b",
                                 $time, exp_ev.event_res, exp_ev.fired_tag,
                                 exp_ev.status, exp_ev.last, rsp_ch.event_res,
                                 rsp_ch.fired_tag, rsp_ch.status, rsp_ch.last);
                    end
                end
            end
        end
    end

    // Watchdog: end a run that never drains.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_callback_timer_table_unit: done, errors");
            $finish;
        end
    end

endmodule
